/* src/ilp_pkg.sv */
// Types, character codes and helper functions for the integer literal parser.
package ilp_pkg;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_BIN    = 6'd2;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] NO_DIGIT    = 6'd63;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_BODY   = 3'd2,
        PH_TRAIL  = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_RANGE = 2'd2,
        ST_RADIX = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [63:0] value;
    } t_out_word;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [5:0] digit_of(logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        priority if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - CH_LOWER_A + 8'd10;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - CH_UPPER_A + 8'd10;
        end else begin
            d = 8'(NO_DIGIT);
        end
        return d[5:0];
    endfunction

endpackage

/* src/int_literal_parser_top.sv */
// Streaming parser that turns a character stream into a signed 64-bit integer.
//
// Takes one character word per cycle while the update stage is not stalled, and
// returns one result word (status and value) for the word marked last. A word
// passes an input register, then the update logic whose critical path is the
// 64 by 6 bit multiply-add of the accumulator and the compare against the
// signed limit; the result register follows and takes the result when the last
// word leaves the update stage. The input side keeps taking a word every cycle
// while a finished result waits at the output, as long as the stage holding the
// next last word is not blocked. The radix register is written through its own
// channel and applies from the next text; write it only while the block is idle.
module int_literal_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ilp_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ilp_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data
);

    logic [5:0]         r_radix;
    logic               r_in_valid;
    ilp_pkg::t_in_word  r_in;
    logic               r_out_valid;
    ilp_pkg::t_out_word r_out;

    logic [63:0]        r_acc;
    ilp_pkg::t_phase    r_phase;
    logic               r_neg;
    logic [5:0]         r_base;
    logic               r_digit_seen;
    logic               r_sep_last;
    logic               r_held_zero;
    ilp_pkg::t_status   r_err;

    logic [63:0]        n_acc;
    ilp_pkg::t_phase    n_phase;
    logic               n_neg;
    logic [5:0]         n_base;
    logic               n_digit_seen;
    logic               n_sep_last;
    logic               n_held_zero;
    ilp_pkg::t_status   n_err;
    ilp_pkg::t_out_word n_out;

    logic               w_fire;

    // The update stage moves unless it holds a last word and the result
    // register is still occupied.
    assign w_fire      = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        logic [7:0]  c;
        logic [7:0]  lc;
        logic [5:0]  d;
        logic        cont;
        logic [63:0] limit;
        logic [69:0] sum;

        n_acc        = r_acc;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_base       = r_base;
        n_digit_seen = r_digit_seen;
        n_sep_last   = r_sep_last;
        n_held_zero  = r_held_zero;
        n_err        = r_err;
        c            = r_in.char_code;
        lc           = c | ilp_pkg::CASE_BIT;
        d            = ilp_pkg::digit_of(c);
        cont         = 1'b1;

        if (r_phase == ilp_pkg::PH_LEAD) begin
            n_base = r_radix;
            n_err  = (r_radix == 6'd1 || r_radix > ilp_pkg::RADIX_MAX) ?
                     ilp_pkg::ST_RADIX : ilp_pkg::ST_OK;
        end

        if (r_in.char_present && n_err == ilp_pkg::ST_OK) begin
            if (n_phase == ilp_pkg::PH_LEAD) begin
                if (ilp_pkg::is_space(c)) begin
                    cont = 1'b0;
                end else begin
                    n_phase = ilp_pkg::PH_PREFIX;
                    if (c == ilp_pkg::CH_PLUS || c == ilp_pkg::CH_MINUS) begin
                        n_neg = (c == ilp_pkg::CH_MINUS);
                        cont  = 1'b0;
                    end
                end
            end

            if (cont && n_phase == ilp_pkg::PH_PREFIX) begin
                if (!n_held_zero) begin
                    if (c == ilp_pkg::CH_ZERO) begin
                        n_held_zero = 1'b1;
                        cont        = 1'b0;
                    end else begin
                        if (n_base == ilp_pkg::RADIX_AUTO) n_base = ilp_pkg::BASE_DEC;
                        n_phase = ilp_pkg::PH_BODY;
                    end
                end else begin
                    n_held_zero = 1'b0;
                    n_phase     = ilp_pkg::PH_BODY;
                    priority if (lc == ilp_pkg::CH_LOWER_X &&
                                 (n_base == ilp_pkg::RADIX_AUTO ||
                                  n_base == ilp_pkg::BASE_HEX)) begin
                        n_base = ilp_pkg::BASE_HEX;
                        cont   = 1'b0;
                    end else if (lc == ilp_pkg::CH_LOWER_O &&
                                 (n_base == ilp_pkg::RADIX_AUTO ||
                                  n_base == ilp_pkg::BASE_OCT)) begin
                        n_base = ilp_pkg::BASE_OCT;
                        cont   = 1'b0;
                    end else if (lc == ilp_pkg::CH_LOWER_B &&
                                 (n_base == ilp_pkg::RADIX_AUTO ||
                                  n_base == ilp_pkg::BASE_BIN)) begin
                        n_base = ilp_pkg::BASE_BIN;
                        cont   = 1'b0;
                    end else begin
                        // The held zero becomes a digit; the accumulator is
                        // still zero, so it cannot overflow.
                        if (n_base == ilp_pkg::RADIX_AUTO) n_base = ilp_pkg::BASE_DEC;
                        n_digit_seen = 1'b1;
                        n_sep_last   = 1'b0;
                    end
                end
            end

            limit = n_neg ? ilp_pkg::POS_LIMIT + 64'd1 : ilp_pkg::POS_LIMIT;
            sum   = {6'd0, r_acc} * {64'd0, n_base} + {64'd0, d};

            if (cont) begin
                if (n_phase == ilp_pkg::PH_BODY) begin
                    priority if (ilp_pkg::is_space(c)) begin
                        n_phase = ilp_pkg::PH_TRAIL;
                    end else if (c == ilp_pkg::CH_UNDERSCORE) begin
                        if (n_sep_last) n_err = ilp_pkg::ST_BAD;
                        else n_sep_last = 1'b1;
                    end else if (n_base < 6'd2 || d >= n_base) begin
                        n_err = ilp_pkg::ST_BAD;
                    end else if (sum > {6'd0, limit}) begin
                        n_err = ilp_pkg::ST_RANGE;
                    end else begin
                        n_acc        = sum[63:0];
                        n_digit_seen = 1'b1;
                        n_sep_last   = 1'b0;
                    end
                end else if (!ilp_pkg::is_space(c)) begin
                    n_err = ilp_pkg::ST_BAD;
                end
            end
        end else begin
            limit = 64'd0;
            sum   = 70'd0;
        end

        if (r_in.last && n_err == ilp_pkg::ST_OK && n_held_zero) begin
            n_held_zero  = 1'b0;
            n_digit_seen = 1'b1;
            n_sep_last   = 1'b0;
        end
        if (r_in.last && (!n_digit_seen || n_sep_last) && n_err == ilp_pkg::ST_OK) begin
            n_err = ilp_pkg::ST_BAD;
        end

        n_out.status = n_err;
        if (n_err == ilp_pkg::ST_OK) begin
            n_out.value = n_neg ? $signed(64'd0 - n_acc) : $signed(n_acc);
        end else begin
            n_out.value = 64'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= ilp_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= 64'd0;
            r_phase      <= ilp_pkg::PH_LEAD;
            r_neg        <= 1'b0;
            r_base       <= ilp_pkg::RADIX_RESET;
            r_digit_seen <= 1'b0;
            r_sep_last   <= 1'b1;
            r_held_zero  <= 1'b0;
            r_err        <= ilp_pkg::ST_OK;
        end else if (w_fire) begin
            if (r_in.last) begin
                // Back to the start-of-text state for the next word stream.
                r_acc        <= 64'd0;
                r_phase      <= ilp_pkg::PH_LEAD;
                r_neg        <= 1'b0;
                r_base       <= r_radix;
                r_digit_seen <= 1'b0;
                r_sep_last   <= 1'b1;
                r_held_zero  <= 1'b0;
                r_err        <= ilp_pkg::ST_OK;
            end else begin
                r_acc        <= n_acc;
                r_phase      <= n_phase;
                r_neg        <= n_neg;
                r_base       <= n_base;
                r_digit_seen <= n_digit_seen;
                r_sep_last   <= n_sep_last;
                r_held_zero  <= n_held_zero;
                r_err        <= n_err;
            end
        end
    end

endmodule
